// File: rtl/rrt_pkg.sv
// rrt_pkg: shared types, codes and constants of the received range tracker.
// Used by every module in rtl/.
package rrt_pkg;

	localparam int POS_W          = 48;
	localparam int MAX_RANGES_DEF = 64;

	localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
	localparam logic [64:0]      OPEN_END = 65'h0_7FFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_DEL     = 2'd1;
	localparam logic [1:0] MODE_GAP     = 2'd2;
	localparam logic [1:0] MODE_CONTAIN = 2'd3;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_CHANGED = 3'd1;
	localparam logic [2:0] ST_RIGHT   = 3'd1;
	localparam logic [2:0] ST_LEFT    = 3'd2;
	localparam logic [2:0] ST_WHOLE   = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	typedef logic signed [64:0] wide_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [48:0] range_pos;
		logic [48:0] range_len;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [POS_W-1:0] data_pos;
		logic [POS_W-1:0] data_len;
		logic [POS_W-1:0] gap_pos;
		logic [48:0]      gap_len;
		logic [POS_W-1:0] received_total;
		logic [6:0]       fragment_count;
		logic             complete;
		logic             table_full;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic push;
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_PREP2,
		S_SCAN,
		S_EDIT,
		S_FIN,
		S_OUT
	} state_t;

	function automatic wide_t zx(input logic [POS_W:0] v);
		return wide_t'({16'b0, v});
	endfunction

	function automatic wide_t sx49(input logic [48:0] v);
		return wide_t'({{16{v[48]}}, v});
	endfunction

	function automatic logic [POS_W-1:0] sat_len(input wide_t v);
		logic [POS_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > zx({1'b0, POS_MAX})) begin
			r = POS_MAX;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/rrt_cell.sv
// rrt_cell: one table slot holding a range (start, size).
// Loads new data when addressed, otherwise takes its right neighbor on a shift.
// Depends on rrt_pkg.
module rrt_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  rrt_pkg::entry_t din,
	input  rrt_pkg::entry_t nbr,
	output rrt_pkg::entry_t q
);

	rrt_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= din;
		end else if (shift) begin
			ent_q <= nbr;
		end
	end

	assign q = ent_q;

endmodule

// File: rtl/rrt_engine.sv
// rrt_engine: sequencer and datapath that streams the cell chain through
// its head, analyzes it, rewrites it, and builds each result.
// Depends on rrt_pkg.
module rrt_engine #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF,
	localparam int CW = $clog2(MAX_RANGES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  rrt_pkg::req_t            req,
	input  logic [rrt_pkg::POS_W-1:0] total_length,
	input  rrt_pkg::entry_t          head,
	output rrt_pkg::chain_ctrl_t     ctrl,
	output logic [CW-1:0]            widx,
	output rrt_pkg::entry_t          wdata,
	output logic                     res_valid,
	input  logic                     res_take,
	output rrt_pkg::rsp_t            res
);

	localparam int MW = $clog2(MAX_RANGES + 2);
	localparam int PW = rrt_pkg::POS_W;

	rrt_pkg::state_t state_q, state_d;

	logic [1:0]    mode_q;
	logic [48:0]   pos_q, len_q;
	logic          done_q, modok_q, edit_en_q, inval_q, full_q, ed_q;
	logic [PW-1:0] s_q, e_q, lim_q;
	rrt_pkg::wide_t cpos_q, clen_q, cend_q, dp_q, key_q;
	logic [CW-1:0] n_q, q_q, k_q;
	logic          has_prev_q, has_next_q, merged_q, emitted_q, inacc_q, ph_q;
	logic [PW:0]   prev_end_q;
	logic [PW-1:0] next_start_q, ms_q, me_q, old_q, removed_q, bytes_q;
	logic [MW-1:0] mcnt_q;
	rrt_pkg::rsp_t res_q;

	logic          done_w, hv, is_add, is_del;
	logic [PW-1:0] a, sz;
	logic [PW:0]   b;
	logic          below, ovl, dov, lo, hi;
	logic          e_pop, e_push, e_emit;
	rrt_pkg::entry_t e_din, newent;

	assign is_add = (mode_q == rrt_pkg::MODE_ADD);
	assign is_del = (mode_q == rrt_pkg::MODE_DEL);
	assign a      = head.start;
	assign sz     = head.size;
	assign b      = {1'b0, a} + {1'b0, sz};
	assign hv     = (k_q != n_q);
	assign done_w = (n_q == CW'(1)) && (head.start == '0) && (total_length != '0)
		&& (head.size == total_length);

	assign below  = b < {1'b0, s_q};
	assign ovl    = !below && (a <= e_q);
	assign dov    = !((b <= {1'b0, s_q}) || (a >= e_q));
	assign lo     = dov && (a < s_q) && !ph_q;
	assign hi     = dov && (b > {1'b0, e_q});
	assign newent = inacc_q ? '{start: ms_q, size: me_q - ms_q}
		: '{start: s_q, size: e_q - s_q};

	// rewrite step for the entry at the head of the chain
	always_comb begin
		e_pop  = 1'b0;
		e_push = 1'b0;
		e_emit = 1'b0;
		e_din  = head;
		if (is_add) begin
			if (!hv) begin
				e_push = !emitted_q;
				e_emit = !emitted_q;
				e_din  = newent;
			end else if (below) begin
				e_pop  = 1'b1;
				e_push = 1'b1;
			end else if (ovl) begin
				e_pop = 1'b1;
			end else if (!emitted_q) begin
				e_push = 1'b1;
				e_emit = 1'b1;
				e_din  = newent;
			end else begin
				e_pop  = 1'b1;
				e_push = 1'b1;
			end
		end else if (hv) begin
			if (!dov) begin
				e_pop  = 1'b1;
				e_push = 1'b1;
			end else if (lo) begin
				e_push = 1'b1;
				e_pop  = !hi;
				e_din  = '{start: a, size: s_q - a};
			end else if (hi) begin
				e_push = 1'b1;
				e_pop  = 1'b1;
				e_din  = '{start: e_q, size: PW'(b - {1'b0, e_q})};
			end else begin
				e_pop = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrt_pkg::S_IDLE:  if (req_valid) state_d = rrt_pkg::S_PREP;
			rrt_pkg::S_PREP:  state_d = rrt_pkg::S_PREP2;
			rrt_pkg::S_PREP2: state_d = rrt_pkg::S_SCAN;
			rrt_pkg::S_SCAN: begin
				if (!hv) begin
					if (edit_en_q && !((is_add && !merged_q && n_q == CW'(MAX_RANGES))
						|| (is_del && mcnt_q > MW'(MAX_RANGES)))) begin
						state_d = rrt_pkg::S_EDIT;
					end else begin
						state_d = rrt_pkg::S_FIN;
					end
				end
			end
			rrt_pkg::S_EDIT:  if (!hv && (is_del || emitted_q)) state_d = rrt_pkg::S_FIN;
			rrt_pkg::S_FIN:   state_d = rrt_pkg::S_OUT;
			rrt_pkg::S_OUT:   if (res_take) state_d = rrt_pkg::S_IDLE;
			default:          state_d = rrt_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl      = '{pop: 1'b0, push: 1'b0};
		widx      = q_q;
		wdata     = head;
		req_stall = (state_q != rrt_pkg::S_IDLE);
		res_valid = (state_q == rrt_pkg::S_OUT);
		res       = res_q;
		res.complete       = done_w;
		res.fragment_count = 7'(n_q);
		res.received_total = bytes_q;
		unique case (state_q)
			rrt_pkg::S_SCAN: begin
				ctrl = '{pop: hv, push: hv};
				widx = n_q - CW'(1);
			end
			rrt_pkg::S_EDIT: begin
				ctrl  = '{pop: e_pop, push: e_push};
				widx  = e_pop ? q_q - CW'(1) : q_q;
				wdata = e_din;
			end
			default: ;
		endcase
	end

	// result arithmetic
	rrt_pkg::wide_t tot_w, rp, glen, cend_w, p_w;
	logic          found;
	logic [PW-1:0] added, e_w;
	logic [PW+1:0] se;
	always_comb begin
		tot_w = rrt_pkg::zx({1'b0, total_length});
		found = has_prev_q && (key_q < rrt_pkg::zx(prev_end_q));
		if (mode_q == rrt_pkg::MODE_GAP) begin
			rp = has_prev_q ? rrt_pkg::zx(prev_end_q) : '0;
		end else begin
			rp = found ? rrt_pkg::zx(prev_end_q) : cpos_q;
		end
		if (has_next_q) begin
			glen = rrt_pkg::zx({1'b0, next_start_q}) - rp;
		end else if (total_length != '0) begin
			glen = tot_w - rp;
		end else begin
			glen = -65'sd1;
		end
		added  = inacc_q ? (me_q - ms_q) - old_q : e_q - s_q;
		se     = {2'b0, s_q} + {1'b0, len_q[48:0]};
		e_w    = (se > {2'b0, lim_q}) ? lim_q : se[PW-1:0];
		cend_w = cpos_q + clen_q;
		p_w    = (dp_q > tot_w) ? tot_w : dp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rrt_pkg::S_IDLE;
			n_q       <= '0;
			bytes_q   <= '0;
			mode_q    <= '0;
			k_q       <= '0;
			q_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				rrt_pkg::S_IDLE: begin
					mode_q <= req.mode;
					pos_q  <= req.range_pos;
					len_q  <= req.range_len;
				end
				rrt_pkg::S_PREP: begin
					done_q  <= done_w;
					lim_q   <= (total_length != '0) ? total_length : rrt_pkg::POS_MAX;
					modok_q <= !pos_q[48] && !len_q[48];
					if (!pos_q[48] && pos_q[PW-1:0] >
						((total_length != '0) ? total_length : rrt_pkg::POS_MAX)) begin
						s_q <= (total_length != '0) ? total_length : rrt_pkg::POS_MAX;
					end else begin
						s_q <= pos_q[PW-1:0];
					end
					cpos_q <= rrt_pkg::sx49(pos_q);
					clen_q <= rrt_pkg::sx49(len_q);
					if (!pos_q[48]) begin
						if (len_q[48]) begin
							clen_q <= (total_length != '0)
								? rrt_pkg::zx({1'b0, total_length}) - rrt_pkg::sx49(pos_q)
								: rrt_pkg::OPEN_END - rrt_pkg::sx49(pos_q);
						end
					end else if (!len_q[48] && len_q != '0 && total_length != '0) begin
						cpos_q <= rrt_pkg::zx({1'b0, total_length}) - rrt_pkg::sx49(len_q);
					end
					if (!pos_q[48]) begin
						dp_q <= rrt_pkg::sx49(pos_q);
					end else if (!len_q[48] && len_q != '0
						&& rrt_pkg::sx49(len_q) <= rrt_pkg::zx({1'b0, total_length})) begin
						dp_q <= rrt_pkg::zx({1'b0, total_length}) - rrt_pkg::sx49(len_q);
					end else begin
						dp_q <= '0;
					end
				end
				rrt_pkg::S_PREP2: begin
					e_q       <= e_w;
					edit_en_q <= (is_add || is_del) && modok_q && (e_w > s_q)
						&& !(is_add && done_q);
					inval_q   <= (cpos_q < 0) || (clen_q < 0);
					cend_q    <= cend_w;
					dp_q      <= p_w;
					key_q     <= (mode_q == rrt_pkg::MODE_GAP) ? rrt_pkg::sx49(pos_q) : cpos_q;
					k_q        <= '0;
					has_prev_q <= 1'b0;
					has_next_q <= 1'b0;
					prev_end_q <= '0;
					next_start_q <= '0;
					merged_q   <= 1'b0;
					mcnt_q     <= '0;
					ed_q       <= 1'b0;
				end
				rrt_pkg::S_SCAN: begin
					if (hv) begin
						k_q <= k_q + CW'(1);
						if (rrt_pkg::zx({1'b0, a}) <= key_q) begin
							has_prev_q <= 1'b1;
							prev_end_q <= b;
						end else if (!has_next_q) begin
							has_next_q   <= 1'b1;
							next_start_q <= a;
						end
						if (ovl) merged_q <= 1'b1;
						if (dov) begin
							mcnt_q <= mcnt_q + MW'(a < s_q) + MW'(b > {1'b0, e_q});
						end else begin
							mcnt_q <= mcnt_q + MW'(1);
						end
					end else begin
						full_q    <= edit_en_q && ((is_add && !merged_q
							&& n_q == CW'(MAX_RANGES)) || (is_del && mcnt_q > MW'(MAX_RANGES)));
						k_q       <= '0;
						q_q       <= n_q;
						emitted_q <= 1'b0;
						inacc_q   <= 1'b0;
						ph_q      <= 1'b0;
						removed_q <= '0;
						old_q     <= '0;
					end
				end
				rrt_pkg::S_EDIT: begin
					ed_q <= 1'b1;
					k_q  <= k_q + CW'(e_pop);
					q_q  <= q_q - CW'(e_pop) + CW'(e_push);
					if (e_emit) emitted_q <= 1'b1;
					if (is_add && hv && ovl) begin
						if (!inacc_q) begin
							ms_q  <= (a < s_q) ? a : s_q;
							me_q  <= (b > {1'b0, e_q}) ? b[PW-1:0] : e_q;
							old_q <= sz;
						end else begin
							me_q  <= (b > {1'b0, me_q}) ? b[PW-1:0] : me_q;
							old_q <= old_q + sz;
						end
						inacc_q <= 1'b1;
					end
					if (is_del && hv) begin
						if (lo && hi) begin
							ph_q <= 1'b1;
						end else if (e_pop) begin
							ph_q <= 1'b0;
						end
						if (dov && e_pop) begin
							removed_q <= removed_q
								+ ((b < {1'b0, e_q}) ? b[PW-1:0] : e_q)
								- ((a > s_q) ? a : s_q);
						end
					end
				end
				rrt_pkg::S_FIN: begin
					res_q <= '0;
					if (ed_q) n_q <= q_q;
					if (mode_q == rrt_pkg::MODE_ADD || mode_q == rrt_pkg::MODE_DEL) begin
						res_q.table_full <= full_q;
						if (ed_q) begin
							if (is_add) begin
								bytes_q <= bytes_q + added;
								res_q.status <= (added != '0) ? rrt_pkg::ST_CHANGED
									: rrt_pkg::ST_NONE;
							end else begin
								bytes_q <= bytes_q - removed_q;
								res_q.status <= (removed_q != '0) ? rrt_pkg::ST_CHANGED
									: rrt_pkg::ST_NONE;
							end
						end
					end else if (mode_q == rrt_pkg::MODE_GAP) begin
						res_q.gap_pos <= rp[PW-1:0];
						res_q.gap_len <= glen[48:0];
						res_q.status  <= (glen > 0) ? rrt_pkg::ST_CHANGED : rrt_pkg::ST_NONE;
					end else if (done_q) begin
						res_q.data_pos <= dp_q[PW-1:0];
						res_q.data_len <= PW'(tot_w - dp_q);
						res_q.gap_pos  <= total_length;
						res_q.status   <= rrt_pkg::ST_WHOLE;
					end else if (inval_q) begin
						res_q.status  <= rrt_pkg::ST_INVALID;
						res_q.gap_len <= '1;
					end else begin
						res_q.gap_pos  <= rp[PW-1:0];
						res_q.gap_len  <= glen[48:0];
						res_q.data_pos <= cpos_q[PW-1:0];
						if (!found) begin
							if (has_next_q && cend_q >= rrt_pkg::zx({1'b0, next_start_q})) begin
								res_q.data_pos <= next_start_q;
								res_q.data_len <= rrt_pkg::sat_len(cend_q
									- rrt_pkg::zx({1'b0, next_start_q}));
								res_q.status   <= rrt_pkg::ST_RIGHT;
							end
						end else if (cend_q > rrt_pkg::zx(prev_end_q)) begin
							res_q.data_len <= rrt_pkg::sat_len(rrt_pkg::zx(prev_end_q) - cpos_q);
							res_q.status   <= rrt_pkg::ST_LEFT;
						end else begin
							res_q.data_len <= rrt_pkg::sat_len(clen_q);
							res_q.status   <= rrt_pkg::ST_WHOLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/received_range_tracker_core.sv
// received_range_tracker_core: top level; cell chain, engine, total-length
// register and result register. Depends on rrt_pkg, rrt_cell, rrt_engine.
//
// Usage: requests arrive on req/req_valid and are taken at an edge where
// req_valid is high and req_stall low. Each request gives one response on
// rsp/rsp_valid, taken at an edge where rsp_valid is high and rsp_stall low.
// cfg_we/cfg_wdata write the total length; write only while idle.
// The table lives in a row of MAX_RANGES cells that shift toward the head.
// An operation first rotates the n stored entries through the head once
// to analyze them; add and delete then rebuild the table in a second pass,
// unless the range is invalid or empty, the add meets a complete table or
// the table would overflow. The states run in order: accept (S_IDLE), setup
// (S_PREP, S_PREP2), scan, rebuild (S_EDIT), result (S_FIN), handoff (S_OUT).
// A finished response waits in the result register while the next request
// is taken; if the receiver still stalls when that one ends, the engine
// holds it until the register frees. Reset empties the table, clears the
// received total and sets the total length to unknown.
module received_range_tracker_core #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  rrt_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rrt_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [rrt_pkg::POS_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_RANGES + 1);

	logic [rrt_pkg::POS_W-1:0] total_q;
	rrt_pkg::entry_t           cq [MAX_RANGES];
	rrt_pkg::chain_ctrl_t      ctrl;
	logic [CW-1:0]             widx;
	rrt_pkg::entry_t           wdata;
	logic                      res_valid, res_take, rsp_valid_q;
	rrt_pkg::rsp_t             res, rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		rrt_cell u_cell (
			.clk   (clk),
			.shift (ctrl.pop),
			.load  (ctrl.push && widx == CW'(i)),
			.din   (wdata),
			.nbr   ((i == MAX_RANGES - 1) ? wdata : cq[(i + 1) % MAX_RANGES]),
			.q     (cq[i])
		);
	end

	rrt_engine #(.MAX_RANGES(MAX_RANGES)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.total_length (total_q),
		.head         (cq[0]),
		.ctrl         (ctrl),
		.widx         (widx),
		.wdata        (wdata),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/rrt_checker.sv
// rrt_sva: port-level assertions for received_range_tracker_core,
// bound to the top level below. Depends on rrt_pkg.
module rrt_sva #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rrt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous transfer still in work");

	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.complete |-> rsp.fragment_count == 7'd1)
		else $error("complete with other than one range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |-> rsp.status == rrt_pkg::ST_NONE
			&& rsp.fragment_count == 7'(MAX_RANGES))
		else $error("table_full on a changed or non-full table");

endmodule

bind received_range_tracker_core rrt_sva #(.MAX_RANGES(MAX_RANGES)) u_rrt_sva (.*);

// File: dv/rrt_checker.sv
// rrt_checker: watches the request, response and config ports of the received range
// tracker, predicts every response and compares it field by field. Depends on rrt_pkg.
module rrt_checker #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  rrt_pkg::req_t             req,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  rrt_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [rrt_pkg::POS_W-1:0] cfg_wdata,
	output int                        fail_count,
	output int                        pending
);
	import rrt_pkg::*;

	localparam longint PMAX = (64'd1 << POS_W) - 1;
	localparam longint OPEN = 64'h7FFF_FFFF_FFFF_FFFF;

	longint frag_lo[MAX_RANGES];
	longint frag_sz[MAX_RANGES];
	longint cut_lo[MAX_RANGES+1];
	longint cut_sz[MAX_RANGES+1];
	int     frag_n;
	longint rx_bytes;
	bit     is_done;
	longint obj_len;
	rsp_t   rsp_fifo[$];

	assign pending = rsp_fifo.size();

	function automatic void refresh_done();
		is_done = frag_n == 1 && frag_lo[0] == 0 && obj_len > 0 && frag_sz[0] == obj_len;
	endfunction

	function automatic bit merge_range(longint s, longint e, ref bit full);
		int i, j;
		longint old, ms, me, added;
		i = 0;
		old = 0;
		while (i < frag_n && frag_lo[i] + frag_sz[i] < s) i++;
		j = i;
		while (j < frag_n && frag_lo[j] <= e) begin
			old += frag_sz[j];
			j++;
		end
		if (i == j) begin
			if (frag_n >= MAX_RANGES) begin
				full = 1;
				return 0;
			end
			for (int k = frag_n; k > i; k--) begin
				frag_lo[k] = frag_lo[k-1];
				frag_sz[k] = frag_sz[k-1];
			end
			frag_lo[i] = s;
			frag_sz[i] = e - s;
			frag_n++;
			rx_bytes += e - s;
			return 1;
		end
		ms = frag_lo[i] < s ? frag_lo[i] : s;
		me = frag_lo[j-1] + frag_sz[j-1];
		if (e > me) me = e;
		frag_lo[i] = ms;
		frag_sz[i] = me - ms;
		for (int k = 0; k < frag_n - j; k++) begin
			frag_lo[i+1+k] = frag_lo[j+k];
			frag_sz[i+1+k] = frag_sz[j+k];
		end
		frag_n = frag_n - (j - i - 1);
		added = (me - ms) - old;
		rx_bytes += added;
		return added > 0;
	endfunction

	function automatic bit cut_range(longint s, longint e, ref bit full);
		int m;
		longint removed, a, b;
		m = 0;
		removed = 0;
		for (int k = 0; k < frag_n; k++) begin
			a = frag_lo[k];
			b = a + frag_sz[k];
			if (b <= s || a >= e) begin
				if (m > MAX_RANGES) break;
				cut_lo[m] = a;
				cut_sz[m] = b - a;
				m++;
				continue;
			end
			removed += (b < e ? b : e) - (a > s ? a : s);
			if (a < s && m <= MAX_RANGES) begin
				cut_lo[m] = a;
				cut_sz[m] = s - a;
				m++;
			end
			if (b > e && m <= MAX_RANGES) begin
				cut_lo[m] = e;
				cut_sz[m] = b - e;
				m++;
			end
		end
		if (m > MAX_RANGES) begin
			full = 1;
			return 0;
		end
		for (int k = 0; k < m; k++) begin
			frag_lo[k] = cut_lo[k];
			frag_sz[k] = cut_sz[k];
		end
		frag_n = m;
		rx_bytes -= removed;
		return removed > 0;
	endfunction

	function automatic int find_slot(longint p, ref bit hit);
		int loc;
		loc = 0;
		while (loc < frag_n && frag_lo[loc] <= p) loc++;
		hit = loc > 0 && p < frag_lo[loc-1] + frag_sz[loc-1];
		return loc;
	endfunction

	function automatic rsp_t track(req_t r);
		rsp_t   o;
		longint pos, len, lim, s, e, p, off, ie, fin;
		bit     full, hit;
		int     loc;
		longint st, dpos, dlen, gpos, glen;
		pos = {{15{r.range_pos[48]}}, r.range_pos};
		len = {{15{r.range_len[48]}}, r.range_len};
		full = 0;
		st = 0; dpos = 0; dlen = 0; gpos = 0; glen = 0;
		if (r.mode == MODE_ADD || r.mode == MODE_DEL) begin
			if (pos >= 0 && len >= 0 && !(r.mode == MODE_ADD && is_done)) begin
				lim = PMAX;
				if (obj_len > 0 && obj_len < lim) lim = obj_len;
				s = pos > lim ? lim : pos;
				e = s + len;
				if (e > lim) e = lim;
				if (e > s) begin
					if (r.mode == MODE_ADD) st = merge_range(s, e, full);
					else st = cut_range(s, e, full);
					refresh_done();
				end
			end
		end else if (r.mode == MODE_GAP) begin
			loc = find_slot(pos, hit);
			off = loc > 0 ? frag_lo[loc-1] + frag_sz[loc-1] : 0;
			if (loc < frag_n) glen = frag_lo[loc] - off;
			else if (obj_len > 0) glen = obj_len - off;
			else glen = -1;
			gpos = off;
			st = glen > 0;
		end else if (is_done) begin
			p = pos;
			if (p < 0) p = (len > 0 && len <= obj_len) ? obj_len - len : 0;
			if (p > obj_len) p = obj_len;
			dpos = p;
			dlen = obj_len - p;
			gpos = obj_len;
			st = ST_WHOLE;
		end else begin
			if (pos >= 0) begin
				if (len < 0) len = obj_len > 0 ? obj_len - pos : OPEN - pos;
			end else if (len > 0 && obj_len > 0) begin
				pos = obj_len - len;
			end
			if (pos < 0 || len < 0) begin
				st = ST_INVALID;
				glen = -1;
			end else begin
				loc = find_slot(pos, hit);
				fin = pos + len;
				if (!hit) begin
					dpos = pos;
					gpos = pos;
					if (loc < frag_n) glen = frag_lo[loc] - pos;
					else glen = obj_len > 0 ? obj_len - pos : -1;
					if (loc < frag_n && fin >= frag_lo[loc]) begin
						dpos = frag_lo[loc];
						dlen = sat_len(wide_t'(fin - frag_lo[loc]));
						st = ST_RIGHT;
					end
				end else begin
					ie = frag_lo[loc-1] + frag_sz[loc-1];
					gpos = ie;
					if (loc < frag_n) glen = frag_lo[loc] - ie;
					else glen = obj_len > 0 ? obj_len - ie : -1;
					dpos = pos;
					if (fin > ie) begin
						dlen = ie - pos > PMAX ? PMAX : ie - pos;
						st = ST_LEFT;
					end else begin
						dlen = len > PMAX ? PMAX : len;
						st = ST_WHOLE;
					end
				end
			end
		end
		o.status         = st[2:0];
		o.data_pos       = dpos[47:0];
		o.data_len       = dlen[47:0];
		o.gap_pos        = gpos[47:0];
		o.gap_len        = glen[48:0];
		o.received_total = rx_bytes[47:0];
		o.fragment_count = frag_n[6:0];
		o.complete       = is_done;
		o.table_full     = full;
		return o;
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t x;
		if (!arst_n) begin
			frag_n = 0;
			rx_bytes = 0;
			is_done = 0;
			obj_len = 0;
			fail_count = 0;
			rsp_fifo.delete();
		end else begin
			if (cfg_we && longint'(cfg_wdata) != obj_len) begin
				obj_len = cfg_wdata;
				refresh_done();
			end
			if (rsp_valid && !rsp_stall) begin
				if (rsp_fifo.size() == 0) begin
					$display("%0t unexpected transfer: expected none actual %h", $time, rsp);
					fail_count++;
				end else begin
					x = rsp_fifo.pop_front();
					check_field("status", x.status, rsp.status);
					check_field("data_pos", x.data_pos, rsp.data_pos);
					check_field("data_len", x.data_len, rsp.data_len);
					check_field("gap_pos", x.gap_pos, rsp.gap_pos);
					check_field("gap_len", x.gap_len, rsp.gap_len);
					check_field("received_total", x.received_total, rsp.received_total);
					check_field("fragment_count", x.fragment_count, rsp.fragment_count);
					check_field("complete", x.complete, rsp.complete);
					check_field("table_full", x.table_full, rsp.table_full);
				end
			end
			if (req_valid && !req_stall)
				rsp_fifo.push_back(track(req));
		end
	end
endmodule

// File: dv/tb.sv
// tb: stimulus and verdict for received_range_tracker_core; the checker rrt_checker
// predicts and compares. Depends on rrt_pkg, received_range_tracker_core, rrt_checker.
module tb;
	import rrt_pkg::*;

	localparam longint PMAX = (64'd1 << POS_W) - 1;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_we;
	logic [POS_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	bit               idle_gaps;
	bit               hold_long;
	longint           obj_len;

	received_range_tracker_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	rrt_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic send(logic [1:0] mode, longint pos, longint len);
		int g;
		g = idle_gaps ? $urandom_range(0, 3) : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{mode: mode, range_pos: pos[48:0], range_len: len[48:0]};
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic set_length(longint v);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[47:0];
		obj_len = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		longint area, pos, len;
		int r;
		logic [1:0] mode;
		area = (obj_len > 0 && obj_len < 100000) ? obj_len + obj_len / 8 + 2 : 4000;
		r = $urandom_range(0, 99);
		mode = r < 45 ? MODE_ADD : r < 60 ? MODE_DEL : r < 75 ? MODE_GAP : MODE_CONTAIN;
		r = $urandom_range(0, 99);
		if (r < 85) pos = $urandom_range(0, int'(area));
		else if (r < 92) pos = -longint'($urandom_range(1, 5000));
		else pos = {{15{1'b0}}, 17'($urandom), $urandom};
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(0, int'(area / 16 + 2));
		else if (r < 80) len = $urandom_range(0, int'(area));
		else if (r < 88) len = -1;
		else if (r < 94) len = PMAX - $urandom_range(0, 3);
		else len = {{15{1'b0}}, 17'($urandom), $urandom};
		pos = {{15{pos[48]}}, pos[48:0]};
		len = {{15{len[48]}}, len[48:0]};
		send(mode, pos, len);
	endtask

	initial begin
		longint lens[7];
		lens = '{0, 100, 4000, 1, PMAX, 2000, 0};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_gaps = 1'b1;
		hold_long = 1'b0;
		obj_len = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown length: extremes, negatives, open-ended queries
		send(MODE_GAP, 0, 0);
		send(MODE_CONTAIN, 0, -1);
		send(MODE_ADD, -1, 10);
		send(MODE_ADD, 5, -1);
		send(MODE_ADD, 10, 20);
		send(MODE_ADD, 30, 5);
		send(MODE_ADD, PMAX, PMAX);
		send(MODE_ADD, PMAX - 10, PMAX);
		send(MODE_CONTAIN, 12, -1);
		send(MODE_CONTAIN, -1, 5);
		send(MODE_GAP, 50, 0);
		send(MODE_DEL, 0, PMAX);
		// known length: complete table, ignored add, split delete
		set_length(100);
		send(MODE_ADD, 0, 150);
		send(MODE_ADD, 3, 4);
		send(MODE_CONTAIN, -1, 30);
		send(MODE_CONTAIN, 500, 1);
		send(MODE_CONTAIN, -1, 300);
		send(MODE_DEL, 40, 10);
		send(MODE_GAP, 45, 0);
		send(MODE_CONTAIN, 30, 40);
		send(MODE_CONTAIN, 45, 20);
		send(MODE_CONTAIN, -1, 60);
		send(MODE_CONTAIN, -1, -1);
		send(MODE_ADD, 40, 10);

		for (int ph = 0; ph < 7; ph++) begin
			set_length(lens[ph]);
			idle_gaps = ph != 2;
			if (ph == 3) hold_long = 1'b1;
			for (int k = 0; k < 180; k++) send_random();
		end

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("received_range_tracker_core regression: pass");
		else
			$display("received_range_tracker_core regression: fail");
		$finish;
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = idle_gaps ? $urandom_range(0, 3) : 0;
			if (hold_long) begin
				hold_long = 1'b0;
				g = 600;
			end
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	initial begin
		#8000000;
		$display("received_range_tracker_core regression: fail");
		$finish;
	end
endmodule
